### rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared sizes for the stream distinct filter and its checker.
// ----------------------------------------------------------------------------
package sdf_pkg;

   localparam int STORE_DEPTH = 128;
   localparam int VALUE_WIDTH = 32;

   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 8;
   localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(STORE_DEPTH + 1);

   // rsp_tdata: echo_value, distinct_count
   localparam int RSP_DATA_W = SAMPLE_W + COUNT_W;

   // rsp_tuser bit positions
   localparam int USER_KEEP     = 0;
   localparam int USER_OVERFLOW = 1;

endpackage

### rtl/sdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/stream_distinct_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_distinct_filter_unit
// Duplicate removal keeping the first occurrence of each value in an array, up to 128 distinct values.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one array element per request: req_tdata is the sample,
//   req_tlast marks the last element of the array.
//   rsp_* returns one result per request: rsp_tdata holds the echoed value
//   and the distinct count, rsp_tuser the keep and overflow flags, rsp_tlast
//   the copy of req_tlast.
//   Each request is compared against the stored distinct values one entry
//   per cycle through the single read port of the store RAM, feeding one
//   shared comparator. The scan covers the distinct values stored so far;
//   a hit ends it early. req_tready stays low from acceptance until the
//   result is moved into the result register, so a new request is only
//   accepted once the previous one is through.
//   The result register frees the input side: a new request is accepted
//   while the previous result still waits. If the receiver stalls, the next
//   result waits inside until the register is free.
//   Reset clears the count and the control state; the store needs no clear
//   since only entries below the count are ever compared.
//   After a request with req_tlast set the count restarts at zero.
// ----------------------------------------------------------------------------
module stream_distinct_filter_unit
   import sdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,  // [31:0] sample_value
   input  logic                  req_tlast,  // end_of_array
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] echo_value, [39:32] distinct_count
   output logic [1:0]            rsp_tuser,  // [0] keep, [1] store_overflow
   output logic                  rsp_tlast   // last_flag
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } sdf_state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_DEPTH);

   sdf_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic                   found_ff, found_in;
   logic                   keep_ff, keep_in;
   logic                   ovf_ff, ovf_in;

   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]    out_value_ff, out_value_in;
   logic [COUNT_W-1:0]     out_count_ff, out_count_in;
   logic                   out_keep_ff, out_keep_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic                   out_last_ff, out_last_in;

   logic [63:0]            sample_wide;
   logic [63:0]            count_wide;
   logic [VALUE_WIDTH-1:0] key;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   ram_wr_en;
   logic                   hit;
   logic                   out_free;

   assign sample_wide = 64'(sample_ff);
   assign key         = sample_wide[VALUE_WIDTH-1:0];
   assign count_wide  = 64'(count_ff);
   assign hit         = cmp_valid_ff && (rd_data == key);
   assign out_free    = !out_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign ram_wr_en   = (state_ff == ST_DECIDE) && !found_ff && (count_ff < FULL_COUNT);

   sdf_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (key),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      found_in     = found_ff;
      keep_in      = keep_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_keep_in  = out_keep_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata;
               last_in   = req_tlast;
               idx_in    = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of entry idx is issued here, compared in the following cycle
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_DECIDE;
            end else if (idx_ff < count_ff) begin
               idx_in       = idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            keep_in = 1'b0;
            ovf_in  = 1'b0;
            if (!found_ff) begin
               if (count_ff < FULL_COUNT) begin
                  count_in = count_ff + 1'b1;
                  keep_in  = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = sample_ff;
               out_count_in = count_wide[COUNT_W-1:0];
               out_keep_in  = keep_ff;
               out_ovf_in   = ovf_ff;
               out_last_in  = last_ff;
               if (last_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      keep_ff      <= keep_in;
      ovf_ff       <= ovf_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_keep_ff  <= out_keep_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_count_ff, out_value_ff};
   assign rsp_tuser  = {out_ovf_ff, out_keep_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/sdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks for the stream distinct filter, bound to the top level.
// ----------------------------------------------------------------------------
module sdf_checker
   import sdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   localparam logic [63:0] FULL_WIDE = 64'(STORE_DEPTH);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("sdf: stalled response changed");

   // one request in flight: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sdf: request accepted while busy");

   // keep and overflow exclude each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[USER_KEEP] && rsp_tuser[USER_OVERFLOW]))
      else $error("sdf: keep and overflow both set");

   // a kept value leaves a nonzero count, overflow only with a full store
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_OVERFLOW]
         |-> rsp_tdata[RSP_DATA_W-1:SAMPLE_W] == FULL_WIDE[COUNT_W-1:0])
      else $error("sdf: overflow without full store");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_KEEP] |-> rsp_tdata[RSP_DATA_W-1:SAMPLE_W] != '0)
      else $error("sdf: kept value with zero count");

endmodule

bind stream_distinct_filter_unit sdf_checker u_sdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
